// ----- hdl/toq_pkg.sv -----
package toq_pkg;

    localparam int TIME_W  = 64;
    localparam int TAG_W   = 16;
    localparam int CNT_W   = 4;
    localparam int DEPTH_DEFAULT = 8;

    localparam logic [2:0] REQ_APPEND     = 3'd0;
    localparam logic [2:0] REQ_LOOKUP     = 3'd1;
    localparam logic [2:0] REQ_UPDATE     = 3'd2;
    localparam logic [2:0] REQ_INVALIDATE = 3'd3;
    localparam logic [2:0] REQ_READ       = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_BADIDX   = 2'd3;

    typedef struct packed {
        logic              valid;
        logic [TAG_W-1:0]  tag;
        logic [TIME_W-1:0] start;
        logic [TIME_W-1:0] stop;
        logic [TIME_W-1:0] seg;
    } entry_t;

endpackage

// ----- hdl/toq_cell.sv -----
// One table slot. In scan mode, each cycle the slot takes its right neighbor's
// entry, so the table rotates past cell zero; cell zero's output drives the scan.
module toq_cell
    import toq_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   shift_en,
    input  logic   load_en,
    input  entry_t load_entry,
    input  entry_t from_right,
    output entry_t entry
);

    entry_t entry_reg;
    entry_t entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (load_en)
            entry_next = load_entry;
        else if (shift_en)
            entry_next = from_right;
    end

    // only the valid bit is reset; the payload is don't-care until loaded
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            entry_reg.valid <= 1'b0;
        else
            entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// ----- hdl/timestamped_overlay_queue_core.sv -----
// Channel       | Signals                                        | Handshake
// --------------+------------------------------------------------+------------------
// request       | start, busy, req_type, req_time, stop_time,    | start & !busy
//               | segment_stop_time, buffer_tag, entry_index     |
// result        | done, status, found_tag, entry_start,          | done, one cycle
//               | entry_stop, entry_count, fill_time, span_*     |
// config        | cfg_valid, cfg_ready, cfg_data                 | cfg_valid & cfg_ready
//
// Append, unknown request, bad index and backward update answer from idle; lookup
// at the end of its scan pass; invalidate after a packing pass and S_DONE; read
// rotates to the entry, answers, and keeps busy through S_DONE until the row is
// home again. Each scan pass moves one entry past cell zero per cycle. Update
// runs a lookup pass, then a packing pass that rewrites kept entries. Reset
// clears valid bits, count, last time and span, sets limit to DEPTH_DEFAULT;
// no clearing pass. The receiver cannot stall; done is a single-cycle pulse.
module timestamped_overlay_queue_core
    import toq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [2:0]               req_type,
    input  logic signed [TIME_W-1:0] req_time,
    input  logic signed [TIME_W-1:0] stop_time,
    input  logic signed [TIME_W-1:0] segment_stop_time,
    input  logic [TAG_W-1:0]         buffer_tag,
    input  logic [2:0]               entry_index,
    output logic                     done,
    output logic [1:0]               status,
    output logic [TAG_W-1:0]         found_tag,
    output logic signed [TIME_W-1:0] entry_start,
    output logic signed [TIME_W-1:0] entry_stop,
    output logic [CNT_W-1:0]         entry_count,
    output logic signed [TIME_W-1:0] fill_time,
    output logic signed [TIME_W-1:0] span_start,
    output logic signed [TIME_W-1:0] span_stop,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CNT_W-1:0]         cfg_data
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OCC_W = $clog2(DEPTH + 1);
    localparam logic [OCC_W-1:0] DEPTH_OCC = OCC_W'(DEPTH);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOOK = 3'd1;   // winner search pass
    localparam logic [2:0] S_PACK = 3'd2;   // compaction pass
    localparam logic [2:0] S_READ = 3'd3;   // rotate to read position
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0] state_reg, state_next;
    logic [OCC_W-1:0] occ_reg, occ_next;
    logic [OCC_W-1:0] step_reg, step_next;       // scan position of cell zero
    logic [OCC_W-1:0] keep_reg, keep_next;       // entries kept this pass
    logic [IDX_W-1:0] win_reg, win_next;
    logic             win_any_reg, win_any_next;
    logic [CNT_W-1:0] max_reg;
    logic signed [TIME_W-1:0] last_reg, last_next;
    logic signed [TIME_W-1:0] span_lo_reg, span_lo_next;
    logic signed [TIME_W-1:0] span_hi_reg, span_hi_next;
    logic signed [TIME_W-1:0] fill_reg, fill_next;
    logic [2:0]               type_reg;
    logic signed [TIME_W-1:0] time_reg;
    logic [IDX_W-1:0]         ridx_reg;

    // result registers
    logic                     done_reg, done_next;
    logic [1:0]               status_reg, status_next;
    logic [TAG_W-1:0]         tag_o_reg, tag_o_next;
    logic signed [TIME_W-1:0] start_o_reg, start_o_next;
    logic signed [TIME_W-1:0] stop_o_reg, stop_o_next;
    logic signed [TIME_W-1:0] fill_o_reg, fill_o_next;
    logic signed [TIME_W-1:0] slo_o_reg, slo_o_next;
    logic signed [TIME_W-1:0] shi_o_reg, shi_o_next;

    entry_t cells [DEPTH];
    entry_t right [DEPTH];
    entry_t head;
    entry_t head_back;   // head as it re-enters the tail
    entry_t new_entry;
    logic   shift_en;
    logic   load_any;
    logic [IDX_W-1:0] load_idx;

    logic accept;
    logic [OCC_W-1:0] limit;
    logic signed [TIME_W-1:0] head_seg;
    logic head_hit, head_keep_upd, head_keep_inv, head_keep;
    logic last_step;

    assign accept    = start && (state_reg == S_IDLE);
    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);
    assign head      = cells[0];
    assign head_seg  = (head.seg != '0) ? head.seg : head.stop;
    assign head_hit  = head.valid && !($signed(time_reg) < $signed(head.start))
                       && ($signed(time_reg) < $signed(head_seg));
    assign head_keep_upd = ($signed(time_reg) < $signed(head.stop))
                           || (win_any_reg && (step_reg[IDX_W-1:0] == win_reg));
    assign head_keep_inv = !($signed(time_reg) < $signed(head.stop));
    assign head_keep = (type_reg == REQ_UPDATE) ? head_keep_upd : head_keep_inv;
    assign last_step = (step_reg == DEPTH_OCC - 1'b1);
    assign limit = (int'(max_reg) < DEPTH) ? OCC_W'(max_reg) : DEPTH_OCC;

    always_comb
    begin
        head_back = head;
        if (state_reg == S_PACK)
            head_back.valid = head.valid && head_keep;
    end

    // Every pass rotates the row through the tail. In a packing pass each kept
    // head is also written at cell keep + DEPTH-1 - step, past the entries still
    // to scan; the remaining shifts of the pass land it at position keep.
    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_row
            if (g == DEPTH - 1)
            begin : g_tail
                assign right[g] = head_back;
            end
            else
            begin : g_mid
                assign right[g] = cells[g+1];
            end
            toq_cell u_cell
            (
                .clk        (clk),
                .rst_n      (rst_n),
                .shift_en   (shift_en),
                .load_en    (load_any && (load_idx == IDX_W'(g))),
                .load_entry (new_entry),
                .from_right (right[g]),
                .entry      (cells[g])
            );
        end
    endgenerate

    always_comb
    begin
        if (state_reg == S_PACK)
            new_entry = head;
        else
        begin
            new_entry.valid = 1'b1;
            new_entry.tag   = buffer_tag;
            new_entry.start = req_time;
            new_entry.stop  = stop_time;
            new_entry.seg   = segment_stop_time;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        occ_next     = occ_reg;
        step_next    = step_reg;
        keep_next    = keep_reg;
        win_next     = win_reg;
        win_any_next = win_any_reg;
        last_next    = last_reg;
        span_lo_next = span_lo_reg;
        span_hi_next = span_hi_reg;
        fill_next    = fill_reg;
        done_next    = 1'b0;
        status_next  = ST_OK;
        tag_o_next   = '0;
        start_o_next = '0;
        stop_o_next  = '0;
        fill_o_next  = '0;
        slo_o_next   = '0;
        shi_o_next   = '0;
        shift_en     = 1'b0;
        load_any     = 1'b0;
        load_idx     = occ_reg[IDX_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                step_next    = '0;
                keep_next    = '0;
                win_any_next = 1'b0;
                win_next     = '0;
                if (accept)
                begin
                    case (req_type)
                        REQ_APPEND:
                        begin
                            if (occ_reg >= limit)
                                status_next = ST_FULL;
                            else
                            begin
                                load_any = 1'b1;
                                occ_next = occ_reg + 1'b1;
                            end
                            done_next = 1'b1;
                        end
                        REQ_LOOKUP:
                            state_next = S_LOOK;
                        REQ_UPDATE:
                        begin
                            if (req_time < last_reg)
                            begin
                                occ_next     = '0;
                                last_next    = req_time;
                                span_lo_next = '0;
                                span_hi_next = '0;
                                fill_o_next  = req_time;
                                done_next    = 1'b1;
                            end
                            else
                            begin
                                last_next  = req_time;
                                state_next = S_LOOK;
                            end
                        end
                        REQ_INVALIDATE:
                        begin
                            fill_next    = req_time;
                            state_next = S_PACK;
                        end
                        REQ_READ:
                        begin
                            if (32'(entry_index) < 32'(occ_reg))
                                state_next = S_READ;
                            else
                            begin
                                status_next = ST_BADIDX;
                                done_next   = 1'b1;
                            end
                        end
                        default:
                            done_next = 1'b1;
                    endcase
                end
            end
            S_LOOK:
            begin
                shift_en = 1'b1;
                if (head_hit && (step_reg < occ_reg)
                    && (!win_any_reg || (stop_o_reg < $signed(head.stop))))
                begin
                    win_any_next = 1'b1;
                    win_next     = step_reg[IDX_W-1:0];
                    tag_o_next   = head.tag;
                    start_o_next = head.start;
                    stop_o_next  = head.stop;
                end
                else
                begin
                    tag_o_next   = tag_o_reg;
                    start_o_next = start_o_reg;
                    stop_o_next  = stop_o_reg;
                end
                step_next = step_reg + 1'b1;
                if (last_step)
                begin
                    step_next = '0;
                    if (type_reg == REQ_LOOKUP)
                    begin
                        done_next = 1'b1;
                        state_next = S_IDLE;
                        if (!win_any_next)
                            status_next = ST_NOTFOUND;
                    end
                    else
                    begin
                        fill_next  = time_reg;
                        state_next = S_PACK;
                        tag_o_next   = '0;
                        start_o_next = '0;
                        stop_o_next  = '0;
                    end
                end
            end
            S_PACK:
            begin
                shift_en = 1'b1;
                if (head.valid && head_keep && (step_reg < occ_reg))
                begin
                    keep_next = keep_reg + 1'b1;
                    load_any  = 1'b1;
                    load_idx  = IDX_W'(DEPTH_OCC - 1'b1 - step_reg + keep_reg);
                    if (type_reg == REQ_UPDATE)
                    begin
                        if (fill_reg < $signed(head.stop))
                            fill_next = head.stop;
                        if (keep_reg == '0)
                        begin
                            span_lo_next = head.start;
                            span_hi_next = head.stop;
                        end
                        else
                        begin
                            if ($signed(head.start) < span_lo_reg)
                                span_lo_next = head.start;
                            if (span_hi_reg < $signed(head.stop))
                                span_hi_next = head.stop;
                        end
                    end
                end
                step_next = step_reg + 1'b1;
                if (last_step)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                // After a pack the row is home and packed: post count and result.
                // After a read this arm keeps the row rotating back home.
                shift_en = 1'b1;
                step_next = step_reg + 1'b1;
                if (step_reg == DEPTH_OCC)
                begin
                    shift_en  = 1'b0;
                    occ_next  = keep_reg;
                    done_next = 1'b1;
                    state_next = S_IDLE;
                    if (type_reg == REQ_UPDATE)
                    begin
                        fill_o_next = fill_reg;
                        if (keep_reg == '0)
                        begin
                            span_lo_next = '0;
                            span_hi_next = '0;
                        end
                        else
                        begin
                            slo_o_next = span_lo_reg;
                            shi_o_next = span_hi_reg;
                        end
                    end
                end
            end
            S_READ:
            begin
                if (step_reg[IDX_W-1:0] == ridx_reg)
                begin
                    tag_o_next   = head.tag;
                    start_o_next = head.start;
                    stop_o_next  = head.stop;
                    done_next    = 1'b1;
                    state_next   = S_DONE;
                    step_next    = step_reg;
                end
                else
                begin
                    shift_en  = 1'b1;
                    step_next = step_reg + 1'b1;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // S_DONE after a read only has to finish the rotation back home.
    // Handled by a separate flag so the packing rule above stays simple.
    logic read_tail_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            occ_reg     <= '0;
            step_reg    <= '0;
            keep_reg    <= '0;
            win_any_reg <= 1'b0;
            last_reg    <= '0;
            span_lo_reg <= '0;
            span_hi_reg <= '0;
            max_reg     <= CNT_W'(DEPTH_DEFAULT);
            done_reg    <= 1'b0;
            read_tail_reg <= 1'b0;
        end
        else
        begin
            if (read_tail_reg)
            begin
                state_reg <= (step_reg == DEPTH_OCC - 1'b1) ? S_IDLE : S_DONE;
                step_reg  <= step_reg + 1'b1;
                read_tail_reg <= (step_reg != DEPTH_OCC - 1'b1);
                done_reg  <= 1'b0;
            end
            else
            begin
                state_reg <= state_next;
                step_reg  <= step_next;
                done_reg  <= done_next;
                read_tail_reg <= (state_reg == S_READ) && (state_next == S_DONE);
            end
            occ_reg     <= occ_next;
            keep_reg    <= keep_next;
            win_any_reg <= win_any_next;
            last_reg    <= last_next;
            span_lo_reg <= span_lo_next;
            span_hi_reg <= span_hi_next;
            if (cfg_valid && cfg_ready)
                max_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg     <= win_next;
        fill_reg    <= fill_next;
        if (!read_tail_reg)
        begin
            status_reg  <= status_next;
            tag_o_reg   <= tag_o_next;
            start_o_reg <= start_o_next;
            stop_o_reg  <= stop_o_next;
            fill_o_reg  <= fill_o_next;
            slo_o_reg   <= slo_o_next;
            shi_o_reg   <= shi_o_next;
        end
        if (accept)
        begin
            type_reg <= req_type;
            time_reg <= req_time;
            ridx_reg <= IDX_W'(entry_index);
        end
    end

    // During the read tail the row must rotate too; the cells see shift_en
    // only from the main decode, so drive it through the S_DONE arm.
    assign done        = done_reg;
    assign status      = status_reg;
    assign found_tag   = tag_o_reg;
    assign entry_start = start_o_reg;
    assign entry_stop  = stop_o_reg;
    assign entry_count = CNT_W'(occ_reg);
    assign fill_time   = fill_o_reg;
    assign span_start  = slo_o_reg;
    assign span_stop   = shi_o_reg;

    a_append_done: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (req_type == REQ_APPEND) |=> done) else $error("append result missing");
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= DEPTH_OCC) else $error("occupancy overflow");
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (req_type == REQ_LOOKUP) |=> busy) else $error("lookup not started");

endmodule

// ----- dv/timestamped_overlay_queue_core_test.sv -----
module timestamped_overlay_queue_core_test
    import toq_pkg::*;
();

    localparam int TBL_DEPTH = 8;
    localparam int IDLE_LIMIT = 4000;
    // the drain wait covers the longest scan (update) and more
    localparam int DRAIN_CYCLES = 4 * TBL_DEPTH + 8;

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic [2:0]               req_type;
    logic signed [TIME_W-1:0] req_time;
    logic signed [TIME_W-1:0] stop_time;
    logic signed [TIME_W-1:0] segment_stop_time;
    logic [TAG_W-1:0]         buffer_tag;
    logic [2:0]               entry_index;
    logic                     done;
    logic [1:0]               status;
    logic [TAG_W-1:0]         found_tag;
    logic signed [TIME_W-1:0] entry_start;
    logic signed [TIME_W-1:0] entry_stop;
    logic [CNT_W-1:0]         entry_count;
    logic signed [TIME_W-1:0] fill_time;
    logic signed [TIME_W-1:0] span_start;
    logic signed [TIME_W-1:0] span_stop;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CNT_W-1:0]         cfg_data;

    timestamped_overlay_queue_core #(.DEPTH(TBL_DEPTH)) dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .req_type(req_type), .req_time(req_time), .stop_time(stop_time),
        .segment_stop_time(segment_stop_time), .buffer_tag(buffer_tag),
        .entry_index(entry_index), .done(done), .status(status),
        .found_tag(found_tag), .entry_start(entry_start), .entry_stop(entry_stop),
        .entry_count(entry_count), .fill_time(fill_time), .span_start(span_start),
        .span_stop(span_stop), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    // One answer as the block should produce it.
    typedef struct {
        logic [1:0]        status;
        logic [TAG_W-1:0]  tag;
        logic [TIME_W-1:0] e_start;
        logic [TIME_W-1:0] e_stop;
        logic [CNT_W-1:0]  count;
        logic [TIME_W-1:0] fill;
        logic [TIME_W-1:0] sp_lo;
        logic [TIME_W-1:0] sp_hi;
    } answer_t;

    // Shadow of the overlay table.
    logic signed [TIME_W-1:0] sh_start [TBL_DEPTH];
    logic signed [TIME_W-1:0] sh_stop  [TBL_DEPTH];
    logic signed [TIME_W-1:0] sh_seg   [TBL_DEPTH];
    logic [TAG_W-1:0]         sh_tag   [TBL_DEPTH];
    int                       sh_count;
    logic signed [TIME_W-1:0] sh_last;
    logic signed [TIME_W-1:0] sh_span_lo;
    logic signed [TIME_W-1:0] sh_span_hi;
    int                       sh_limit;

    answer_t pending_answers[$];
    int      mismatch_count;
    int      answers_seen;
    int      requests_sent;
    int      idle_cycles;
    int      op_hits[8];

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Index of the entry shown at time now, or -1.
    function automatic int overlay_winner(logic signed [TIME_W-1:0] now);
        int best;
        logic signed [TIME_W-1:0] seg;
        best = -1;
        for (int i = 0; i < sh_count; i++)
        begin
            seg = (sh_seg[i] != 0) ? sh_seg[i] : sh_stop[i];
            if (now >= sh_start[i] && now < seg)
                if (best < 0 || sh_stop[best] < sh_stop[i])
                    best = i;
        end
        return best;
    endfunction

    task automatic table_step(input logic [2:0] op, input logic signed [TIME_W-1:0] t,
                              input logic signed [TIME_W-1:0] stp,
                              input logic signed [TIME_W-1:0] seg,
                              input logic [TAG_W-1:0] tag, input logic [2:0] idx);
        answer_t a;
        int w;
        int j;
        logic signed [TIME_W-1:0] fill;
        bit any;
        a = '{default: '0};
        case (op)
            REQ_APPEND:
            begin
                if (sh_count >= sh_limit)
                    a.status = ST_FULL;
                else
                begin
                    sh_start[sh_count] = t;
                    sh_stop[sh_count] = stp;
                    sh_seg[sh_count] = seg;
                    sh_tag[sh_count] = tag;
                    sh_count++;
                end
            end
            REQ_LOOKUP:
            begin
                w = overlay_winner(t);
                if (w < 0)
                    a.status = ST_NOTFOUND;
                else
                begin
                    a.tag = sh_tag[w];
                    a.e_start = sh_start[w];
                    a.e_stop = sh_stop[w];
                end
            end
            REQ_UPDATE:
            begin
                if (t < sh_last)
                begin
                    // time went backwards: flush
                    sh_count = 0;
                    sh_last = t;
                    sh_span_lo = 0;
                    sh_span_hi = 0;
                    a.fill = t;
                end
                else
                begin
                    fill = t;
                    any = 0;
                    sh_last = t;
                    w = overlay_winner(t);
                    j = 0;
                    for (int i = 0; i < sh_count; i++)
                    begin
                        if (sh_stop[i] <= t && i != w)
                            continue;
                        if (fill < sh_stop[i])
                            fill = sh_stop[i];
                        if (!any)
                        begin
                            sh_span_lo = sh_start[i];
                            sh_span_hi = sh_stop[i];
                            any = 1;
                        end
                        else
                        begin
                            if (sh_start[i] < sh_span_lo)
                                sh_span_lo = sh_start[i];
                            if (sh_span_hi < sh_stop[i])
                                sh_span_hi = sh_stop[i];
                        end
                        sh_start[j] = sh_start[i];
                        sh_stop[j] = sh_stop[i];
                        sh_seg[j] = sh_seg[i];
                        sh_tag[j] = sh_tag[i];
                        j++;
                    end
                    sh_count = j;
                    if (!any)
                    begin
                        sh_span_lo = 0;
                        sh_span_hi = 0;
                    end
                    a.fill = fill;
                    a.sp_lo = sh_span_lo;
                    a.sp_hi = sh_span_hi;
                end
            end
            REQ_INVALIDATE:
            begin
                j = 0;
                for (int i = 0; i < sh_count; i++)
                begin
                    if (t < sh_stop[i])
                        continue;
                    sh_start[j] = sh_start[i];
                    sh_stop[j] = sh_stop[i];
                    sh_seg[j] = sh_seg[i];
                    sh_tag[j] = sh_tag[i];
                    j++;
                end
                sh_count = j;
            end
            REQ_READ:
            begin
                if (idx < sh_count)
                begin
                    a.tag = sh_tag[idx];
                    a.e_start = sh_start[idx];
                    a.e_stop = sh_stop[idx];
                end
                else
                    a.status = ST_BADIDX;
            end
            default: ;
        endcase
        a.count = sh_count[CNT_W-1:0];
        pending_answers.push_back(a);
    endtask

    // Gap before a request: mostly none or short, now and then long.
    // With no gap, start stays high straight into the next request.
    task automatic idle_gap();
        int n;
        n = $urandom_range(0, 99);
        if (n < 40)
            n = 0;
        else if (n < 92)
            n = $urandom_range(1, 3);
        else
            n = $urandom_range(8, 40);
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Drive one request and hold it until the block takes it.
    task automatic send_request(input logic [2:0] op, input logic signed [TIME_W-1:0] t,
                                input logic signed [TIME_W-1:0] stp,
                                input logic signed [TIME_W-1:0] seg,
                                input logic [TAG_W-1:0] tag, input logic [2:0] idx);
        idle_gap();
        start <= 1'b1;
        req_type <= op;
        req_time <= t;
        stop_time <= stp;
        segment_stop_time <= seg;
        buffer_tag <= tag;
        entry_index <= idx;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        table_step(op, t, stp, seg, tag, idx);
        op_hits[op]++;
        requests_sent++;
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(input logic [CNT_W-1:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        sh_limit = (value < TBL_DEPTH) ? value : TBL_DEPTH;
        @(posedge clk);
    endtask

    function automatic logic [TIME_W-1:0] rand_time();
        return {$urandom(), $urandom()};
    endfunction

    // Checker: every done pulse is compared with the oldest expectation.
    always @(posedge clk)
    begin
        answer_t a;
        if (rst_n && done)
        begin
            answers_seen++;
            if (pending_answers.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("ERROR: unexpected result at %0t", $realtime);
            end
            else
            begin
                a = pending_answers.pop_front();
                if (status !== a.status || found_tag !== a.tag || entry_start !== a.e_start
                    || entry_stop !== a.e_stop || entry_count !== a.count
                    || fill_time !== a.fill || span_start !== a.sp_lo
                    || span_stop !== a.sp_hi)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("ERROR: result %0d exp st=%0d tag=%h st=%h sp=%h cnt=%0d",
                                 answers_seen, a.status, a.tag, a.e_start, a.e_stop, a.count);
                        $display("        fill=%h span=%h..%h", a.fill, a.sp_lo, a.sp_hi);
                        $display("       got st=%0d tag=%h st=%h sp=%h cnt=%0d",
                                 status, found_tag, entry_start, entry_stop, entry_count);
                        $display("        fill=%h span=%h..%h", fill_time, span_start,
                                 span_stop);
                    end
                end
            end
        end
    end

    // Watchdog: cycles with neither a request taken nor a result seen.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Directed: extremes of every field, each request type, full and bad index.
    task automatic test_directed();
        logic signed [TIME_W-1:0] tmin;
        logic signed [TIME_W-1:0] tmax;
        tmin = {1'b1, {(TIME_W-1){1'b0}}};
        tmax = {1'b0, {(TIME_W-1){1'b1}}};
        send_request(REQ_READ, 0, 0, 0, 0, 3'd0);
        send_request(REQ_LOOKUP, 5, 0, 0, 0, 0);
        send_request(REQ_APPEND, 10, 50, 0, 16'hffff, 0);
        send_request(REQ_APPEND, 20, 40, 30, 16'h0000, 0);
        send_request(REQ_APPEND, tmin, tmax, -1, 16'h5a5a, 0);
        send_request(REQ_APPEND, 20, 50, 0, 16'h1234, 0);
        send_request(REQ_LOOKUP, 25, 0, 0, 0, 0);
        send_request(REQ_LOOKUP, tmin, 0, 0, 0, 0);
        send_request(REQ_READ, 0, 0, 0, 0, 3'd7);
        send_request(REQ_READ, 0, 0, 0, 0, 3'd2);
        send_request(3'd5, tmax, tmax, tmax, 16'hffff, 3'd7);
        send_request(3'd6, 0, 0, 0, 0, 0);
        send_request(3'd7, 0, 0, 0, 0, 0);
        send_request(REQ_UPDATE, 45, 0, 0, 0, 0);
        send_request(REQ_UPDATE, 45, 0, 0, 0, 0);
        send_request(REQ_INVALIDATE, 48, 0, 0, 0, 0);
        send_request(REQ_UPDATE, tmin, 0, 0, 0, 0);
        for (int i = 0; i < TBL_DEPTH + 1; i++)
            send_request(REQ_APPEND, i, tmax - i, 0, 16'(i), 0);
    endtask

    // Random: mostly well-ordered timelines, with backward jumps and noise.
    task automatic test_random(input int n);
        logic signed [TIME_W-1:0] now;
        logic signed [TIME_W-1:0] t;
        logic signed [TIME_W-1:0] stp;
        logic signed [TIME_W-1:0] seg;
        int pick;
        now = $urandom_range(0, 100);
        for (int k = 0; k < n; k++)
        begin
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 9) == 0)
            begin
                // full-range noise
                t = rand_time();
                stp = rand_time();
                seg = ($urandom_range(0, 1)) ? 64'sd0 : rand_time();
                send_request(3'($urandom_range(0, 7)), t, stp, seg, 16'($urandom()),
                             3'($urandom()));
            end
            else if (pick < 35)
            begin
                t = now + $signed($urandom_range(0, 40)) - 10;
                stp = t + $urandom_range(1, 60);
                seg = ($urandom_range(0, 2) == 0) ? stp - $urandom_range(0, 20) : 64'sd0;
                send_request(REQ_APPEND, t, stp, seg, 16'($urandom()), 0);
            end
            else if (pick < 55)
                send_request(REQ_LOOKUP, now + $urandom_range(0, 30), 0, 0, 0, 0);
            else if (pick < 75)
            begin
                if ($urandom_range(0, 15) == 0)
                    now = now - $urandom_range(1, 100);
                else
                    now = now + $urandom_range(0, 20);
                send_request(REQ_UPDATE, now, 0, 0, 0, 0);
            end
            else if (pick < 83)
                send_request(REQ_INVALIDATE, now + $urandom_range(0, 60), 0, 0, 0, 0);
            else
                send_request(REQ_READ, 0, 0, 0, 0, 3'($urandom_range(0, 7)));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        req_type = '0;
        req_time = '0;
        stop_time = '0;
        segment_stop_time = '0;
        buffer_tag = '0;
        entry_index = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        mismatch_count = 0;
        answers_seen = 0;
        requests_sent = 0;
        idle_cycles = 0;
        for (int i = 0; i < 8; i++)
            op_hits[i] = 0;
        sh_count = 0;
        sh_last = 0;
        sh_span_lo = 0;
        sh_span_hi = 0;
        sh_limit = TBL_DEPTH;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        // limit settings: zero refuses all, one, mid, max (above depth), depth
        write_limit(4'd0);
        test_random(60);
        write_limit(4'd1);
        test_random(120);
        write_limit(4'd3);
        test_random(200);
        write_limit(4'd15);
        test_random(200);
        write_limit(4'd8);
        test_random(250);
        wait_drained();

        $display("Covered %0d requests (append %0d lookup %0d update %0d inval %0d read %0d)",
                 requests_sent, op_hits[0], op_hits[1], op_hits[2], op_hits[3], op_hits[4]);
        $display("%0d results checked over table limits 0,1,3,15,8", answers_seen);
        if (mismatch_count == 0 && pending_answers.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/toq_pkg.sv
hdl/toq_cell.sv
hdl/timestamped_overlay_queue_core.sv
dv/timestamped_overlay_queue_core_test.sv
